// ----- sv/ihpq_pkg.sv -----
// ----------------------------------------------------------------------------
// ihpq_pkg - shared types and constants of the indexed min-heap queue
// Sizes, operation and status codes, controller states and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
package ihpq_pkg;

   localparam int CAPACITY     = 256;
   localparam int DIST_WIDTH   = 31;
   localparam int VTX_W        = 8;
   localparam int VERTEX_COUNT = 1 << VTX_W;
   localparam int DIST_FIELD_W = 31;
   localparam int FUNC_W       = 2;
   localparam int STATUS_W     = 2;

   // stored key width: the field never carries more than 31 bits
   localparam int DW     = (DIST_WIDTH < DIST_FIELD_W) ? DIST_WIDTH : DIST_FIELD_W;
   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int SLOT_W = ADDR_W + 1;
   localparam int HEAP_W = VTX_W + DW;

   localparam int REQ_DATA_W = ((VTX_W + DIST_FIELD_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((VTX_W + DIST_FIELD_W + 1 + 7) / 8) * 8;

   typedef enum logic [FUNC_W-1:0] {
      FN_LOAD     = 2'd0,
      FN_EXTRACT  = 2'd1,
      FN_DECREASE = 2'd2,
      FN_QUERY    = 2'd3
   } func_type;

   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_REJECT = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_EXT_LAST,
      S_EXT_SLOT0,
      S_SD_LEFT,
      S_SD_EVAL_L,
      S_SD_EVAL_R,
      S_SD_DEC,
      S_SD_SWAP2,
      S_DK_LOAD,
      S_SU_READ,
      S_SU_CMP,
      S_DONE
   } state_type;

   typedef enum logic [4:0] {
      CMD_NONE,
      CMD_ACCEPT,
      CMD_LOAD,
      CMD_FAIL_EMPTY,
      CMD_FAIL,
      CMD_QUERY,
      CMD_EXT_START,
      CMD_EXT_LAST,
      CMD_EXT_SLOT0,
      CMD_DK_START,
      CMD_DK_LOAD,
      CMD_SD_LEFT,
      CMD_SD_EVAL_L,
      CMD_SD_EVAL_R,
      CMD_SD_SWAP,
      CMD_SD_SWAP2,
      CMD_SU_READ,
      CMD_SU_SWAP,
      CMD_FIN,
      CMD_PUSH
   } step_type;

   typedef struct packed {
      step_type step;
   } cmd_type;

   typedef struct packed {
      func_type func;
      logic     full;
      logic     empty;
      logic     present;
      logic     left_ok;
      logic     right_ok;
      logic     take;
      logic     idx_zero;
      logic     up_less;
      logic     rsp_free;
   } stat_type;

endpackage

// ----- sv/ihpq_ram.sv -----
// ----------------------------------------------------------------------------
// ihpq_ram - generic simple dual-port RAM
// One write port, one read port with enable and registered read data.
// ----------------------------------------------------------------------------
module ihpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/ihpq_ctrl.sv -----
// ----------------------------------------------------------------------------
// ihpq_ctrl - sequencer of the heap queue
// Walks each operation through its steps and issues one command a cycle, none while a result waits in the done state.
// ----------------------------------------------------------------------------
module ihpq_ctrl
   import ihpq_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd.step   = CMD_NONE;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.step = CMD_ACCEPT;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (stat.func)
               FN_LOAD: begin
                  cmd.step = stat.full ? CMD_FAIL : CMD_LOAD;
                  state_in = S_DONE;
               end
               FN_EXTRACT: begin
                  if (stat.empty) begin
                     cmd.step = CMD_FAIL_EMPTY;
                     state_in = S_DONE;
                  end else begin
                     cmd.step = CMD_EXT_START;
                     state_in = S_EXT_LAST;
                  end
               end
               FN_DECREASE: begin
                  if (stat.present) begin
                     cmd.step = CMD_DK_START;
                     state_in = S_DK_LOAD;
                  end else begin
                     cmd.step = CMD_FAIL;
                     state_in = S_DONE;
                  end
               end
               default: begin
                  cmd.step = CMD_QUERY;
                  state_in = S_DONE;
               end
            endcase
         end
         S_EXT_LAST: begin
            cmd.step = CMD_EXT_LAST;
            state_in = S_EXT_SLOT0;
         end
         S_EXT_SLOT0: begin
            cmd.step = CMD_EXT_SLOT0;
            state_in = S_SD_LEFT;
         end
         S_SD_LEFT: begin
            if (stat.left_ok) begin
               cmd.step = CMD_SD_LEFT;
               state_in = S_SD_EVAL_L;
            end else begin
               cmd.step = CMD_FIN;
               state_in = S_DONE;
            end
         end
         S_SD_EVAL_L: begin
            cmd.step = CMD_SD_EVAL_L;
            state_in = stat.right_ok ? S_SD_EVAL_R : S_SD_DEC;
         end
         S_SD_EVAL_R: begin
            cmd.step = CMD_SD_EVAL_R;
            state_in = S_SD_DEC;
         end
         S_SD_DEC: begin
            if (stat.take) begin
               cmd.step = CMD_SD_SWAP;
               state_in = S_SD_SWAP2;
            end else begin
               cmd.step = CMD_FIN;
               state_in = S_DONE;
            end
         end
         S_SD_SWAP2: begin
            cmd.step = CMD_SD_SWAP2;
            state_in = S_SD_LEFT;
         end
         S_DK_LOAD: begin
            cmd.step = CMD_DK_LOAD;
            state_in = S_SU_READ;
         end
         S_SU_READ: begin
            if (stat.idx_zero) begin
               cmd.step = CMD_FIN;
               state_in = S_DONE;
            end else begin
               cmd.step = CMD_SU_READ;
               state_in = S_SU_CMP;
            end
         end
         S_SU_CMP: begin
            if (stat.up_less) begin
               cmd.step = CMD_SU_SWAP;
               state_in = S_SU_READ;
            end else begin
               cmd.step = CMD_FIN;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (stat.rsp_free) begin
               cmd.step = CMD_PUSH;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ----- sv/ihpq_dpath.sv -----
// ----------------------------------------------------------------------------
// ihpq_dpath - heap store, slot map and result register
// Holds the heap RAM, the vertex-to-slot RAM with its valid bits, the
// moving entry of a sift and the output word register.
// ----------------------------------------------------------------------------
module ihpq_dpath
   import ihpq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output stat_type              stat,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [FUNC_W-1:0]     req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [STATUS_W-1:0]   rsp_tuser
);

   // request and result registers
   func_type              func_ff,  func_in;
   logic [VTX_W-1:0]      vtx_ff,   vtx_in;
   logic [DW-1:0]         dist_ff,  dist_in;
   logic [VTX_W-1:0]      res_v_ff, res_v_in;
   logic [DW-1:0]         res_d_ff, res_d_in;
   logic [STATUS_W-1:0]   res_st_ff, res_st_in;
   logic                  res_ih_ff, res_ih_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [STATUS_W-1:0]   rsp_user_ff, rsp_user_in;

   // heap walk registers
   logic [SLOT_W-1:0]     count_ff, count_in;
   logic [SLOT_W-1:0]     idx_ff,   idx_in;
   logic [SLOT_W-1:0]     best_ff,  best_in;
   logic [VTX_W-1:0]      mv_v_ff,  mv_v_in;
   logic [DW-1:0]         mv_d_ff,  mv_d_in;
   logic [VTX_W-1:0]      c_v_ff,   c_v_in;
   logic [DW-1:0]         c_d_ff,   c_d_in;
   logic [DW-1:0]         best_d_ff, best_d_in;
   logic                  take_ff,  take_in;
   logic                  moved_ff, moved_in;

   // slot map valid bits: an entry not yet written reads as absent
   logic [VERTEX_COUNT-1:0] slot_vld_ff;
   logic                    slot_hit_ff;

   // RAM ports
   logic              hp_we, hp_re;
   logic [ADDR_W-1:0] hp_wa, hp_ra;
   logic [HEAP_W-1:0] hp_wd, hp_q;
   logic              sl_we, sl_re;
   logic [VTX_W-1:0]  sl_wa, sl_ra;
   logic [SLOT_W-1:0] sl_wd, sl_q;

   logic [VTX_W-1:0]      hp_v;
   logic [DW-1:0]         hp_d;
   logic [SLOT_W-1:0]     slot_q;
   logic [SLOT_W-1:0]     last_idx;
   logic [SLOT_W:0]       lidx, ridx;
   logic [SLOT_W-1:0]     pidx;
   logic [VTX_W-1:0]      req_vtx;
   logic [DIST_FIELD_W-1:0] req_dist;

   function automatic logic [SLOT_W-1:0] parent_of(input logic [SLOT_W-1:0] i);
      logic [SLOT_W-1:0] dec;
      dec = i - 1'b1;
      return dec >> 1;
   endfunction

   assign hp_v     = hp_q[VTX_W-1:0];
   assign hp_d     = hp_q[HEAP_W-1:VTX_W];
   assign slot_q   = slot_hit_ff ? sl_q : {SLOT_W{1'b1}};
   assign last_idx = count_ff - 1'b1;
   assign lidx     = {idx_ff, 1'b1};
   assign ridx     = lidx + 1'b1;
   assign pidx     = parent_of(idx_ff);
   assign req_vtx  = req_tdata[VTX_W-1:0];
   assign req_dist = req_tdata[VTX_W+DIST_FIELD_W-1:VTX_W];

   ihpq_ram #(.WIDTH(HEAP_W), .DEPTH(CAPACITY)) u_heap_ram (
      .clock   (clock),
      .wr_en   (hp_we),
      .wr_addr (hp_wa),
      .wr_data (hp_wd),
      .rd_en   (hp_re),
      .rd_addr (hp_ra),
      .rd_data (hp_q)
   );

   ihpq_ram #(.WIDTH(SLOT_W), .DEPTH(VERTEX_COUNT)) u_slot_ram (
      .clock   (clock),
      .wr_en   (sl_we),
      .wr_addr (sl_wa),
      .wr_data (sl_wd),
      .rd_en   (sl_re),
      .rd_addr (sl_ra),
      .rd_data (sl_q)
   );

   always_comb begin
      func_in   = func_ff;
      vtx_in    = vtx_ff;
      dist_in   = dist_ff;
      res_v_in  = res_v_ff;
      res_d_in  = res_d_ff;
      res_st_in = res_st_ff;
      res_ih_in = res_ih_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      best_in   = best_ff;
      mv_v_in   = mv_v_ff;
      mv_d_in   = mv_d_ff;
      c_v_in    = c_v_ff;
      c_d_in    = c_d_ff;
      best_d_in = best_d_ff;
      take_in   = take_ff;
      moved_in  = moved_ff;
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      hp_we = 1'b0;
      hp_wa = idx_ff[ADDR_W-1:0];
      hp_wd = {mv_d_ff, mv_v_ff};
      hp_re = 1'b0;
      hp_ra = '0;
      sl_we = 1'b0;
      sl_wa = mv_v_ff;
      sl_wd = idx_ff;
      sl_re = 1'b0;
      sl_ra = req_vtx;
      case (cmd.step)
         CMD_ACCEPT: begin
            func_in   = func_type'(req_tuser);
            vtx_in    = req_vtx;
            dist_in   = req_dist[DW-1:0];
            res_v_in  = '0;
            res_d_in  = '0;
            res_st_in = ST_OK;
            res_ih_in = 1'b0;
            sl_re     = 1'b1;
            hp_re     = 1'b1;   // root, in case this is an extract
         end
         CMD_LOAD: begin
            hp_we    = 1'b1;
            hp_wa    = count_ff[ADDR_W-1:0];
            hp_wd    = {dist_ff, vtx_ff};
            sl_we    = 1'b1;
            sl_wa    = vtx_ff;
            sl_wd    = count_ff;
            count_in = count_ff + 1'b1;
         end
         CMD_FAIL_EMPTY: res_st_in = ST_EMPTY;
         CMD_FAIL:       res_st_in = ST_REJECT;
         CMD_QUERY:      res_ih_in = (slot_q < count_ff);
         CMD_EXT_START: begin
            res_v_in = hp_v;
            res_d_in = hp_d;
            hp_re    = 1'b1;
            hp_ra    = last_idx[ADDR_W-1:0];
         end
         CMD_EXT_LAST: begin
            mv_v_in  = hp_v;
            mv_d_in  = hp_d;
            sl_we    = 1'b1;
            sl_wa    = res_v_ff;
            sl_wd    = last_idx;
            count_in = last_idx;
            idx_in   = '0;
            moved_in = 1'b0;
         end
         CMD_EXT_SLOT0: begin
            sl_we = 1'b1;
            sl_wa = mv_v_ff;
            sl_wd = '0;
         end
         CMD_DK_START: begin
            idx_in = slot_q;
            hp_re  = 1'b1;
            hp_ra  = slot_q[ADDR_W-1:0];
         end
         CMD_DK_LOAD: begin
            mv_v_in  = hp_v;
            mv_d_in  = dist_ff;
            moved_in = 1'b0;
         end
         CMD_SD_LEFT: begin
            hp_re = 1'b1;
            hp_ra = lidx[ADDR_W-1:0];
         end
         CMD_SD_EVAL_L: begin
            if (hp_d < mv_d_ff) begin
               take_in   = 1'b1;
               best_in   = lidx[SLOT_W-1:0];
               c_v_in    = hp_v;
               c_d_in    = hp_d;
               best_d_in = hp_d;
            end else begin
               take_in   = 1'b0;
               best_d_in = mv_d_ff;
            end
            hp_re = stat.right_ok;
            hp_ra = ridx[ADDR_W-1:0];
         end
         CMD_SD_EVAL_R: begin
            // strict compare keeps the left child on a tie
            if (hp_d < best_d_ff) begin
               take_in = 1'b1;
               best_in = ridx[SLOT_W-1:0];
               c_v_in  = hp_v;
               c_d_in  = hp_d;
            end
         end
         CMD_SD_SWAP: begin
            hp_we = 1'b1;
            hp_wd = {c_d_ff, c_v_ff};
            sl_we = 1'b1;
            sl_wa = mv_v_ff;
            sl_wd = best_ff;
         end
         CMD_SD_SWAP2: begin
            sl_we  = 1'b1;
            sl_wa  = c_v_ff;
            sl_wd  = idx_ff;
            idx_in = best_ff;
         end
         CMD_SU_READ: begin
            hp_re = 1'b1;
            hp_ra = pidx[ADDR_W-1:0];
         end
         CMD_SU_SWAP: begin
            hp_we    = 1'b1;
            hp_wd    = hp_q;
            sl_we    = 1'b1;
            sl_wa    = hp_v;
            sl_wd    = idx_ff;
            idx_in   = pidx;
            moved_in = 1'b1;
         end
         CMD_FIN: begin
            // moving entry lands; after a sift up its map entry follows it
            hp_we = 1'b1;
            sl_we = moved_ff;
         end
         CMD_PUSH: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = '0;
            rsp_data_in[VTX_W-1:0]               = res_v_ff;
            rsp_data_in[VTX_W +: DIST_FIELD_W]   = DIST_FIELD_W'(res_d_ff);
            rsp_data_in[VTX_W + DIST_FIELD_W]    = res_ih_ff;
            rsp_user_in  = res_st_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         slot_vld_ff  <= '0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (sl_we) begin
            slot_vld_ff[sl_wa] <= 1'b1;
         end
      end
      if (sl_re) begin
         slot_hit_ff <= slot_vld_ff[sl_ra];
      end
      func_ff     <= func_in;
      vtx_ff      <= vtx_in;
      dist_ff     <= dist_in;
      res_v_ff    <= res_v_in;
      res_d_ff    <= res_d_in;
      res_st_ff   <= res_st_in;
      res_ih_ff   <= res_ih_in;
      idx_ff      <= idx_in;
      best_ff     <= best_in;
      mv_v_ff     <= mv_v_in;
      mv_d_ff     <= mv_d_in;
      c_v_ff      <= c_v_in;
      c_d_ff      <= c_d_in;
      best_d_ff   <= best_d_in;
      take_ff     <= take_in;
      moved_ff    <= moved_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign stat.func     = func_ff;
   assign stat.full     = (count_ff >= SLOT_W'(CAPACITY));
   assign stat.empty    = (count_ff == '0);
   assign stat.present  = (slot_q < count_ff);
   assign stat.left_ok  = (lidx < {1'b0, count_ff});
   assign stat.right_ok = (ridx < {1'b0, count_ff});
   assign stat.take     = take_ff;
   assign stat.idx_zero = (idx_ff == '0);
   assign stat.up_less  = (mv_d_ff < hp_d);
   assign stat.rsp_free = ~rsp_valid_ff | rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= SLOT_W'(CAPACITY))
      else $error("entry count beyond capacity");

   a_push_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.step == CMD_PUSH) |-> (~rsp_valid_ff | rsp_tready))
      else $error("result overwritten before it was taken");

   a_load_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.step == CMD_LOAD) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("load did not grow the heap");

   a_ext_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.step == CMD_EXT_LAST) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("extract did not shrink the heap");

endmodule

// ----- sv/indexed_min_heap_priority_queue.sv -----
// ----------------------------------------------------------------------------
// indexed_min_heap_priority_queue - indexed binary min-heap
// Heap of (vertex, distance) words with a vertex-to-slot map: load, extract
// minimum, decrease key and membership query.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake            tdata (low bit up)               tuser
//  req_     in   req_tvalid/tready    vertex[7:0], distance[38:8]      func
//  rsp_     out  rsp_tvalid/tready    out_vertex[7:0],                 status
//                                     out_distance[38:8], in_heap[39]
//
//  Load, query and rejected words are handled without a sift; decrease key sifts
//  up a level at a time and extract sifts down a level at a time, reading only
//  the left child where there is no right child. A sift step reads one or two
//  entries through the single read port of the heap RAM, compares and writes
//  the swap.
//  Reset: synchronous, active high; empties the heap and clears the slot map
//  valid bits directly, with no sweep.
//  Stalls: a finished word waits in the output register; the next request is
//  taken meanwhile and only its own result waits for that register to free.
//
module indexed_min_heap_priority_queue
   import ihpq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // vertex, distance, zero pad
   input  logic [FUNC_W-1:0]     req_tuser,   // func
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // out_vertex, out_distance, in_heap
   output logic [STATUS_W-1:0]   rsp_tuser    // status
);

   cmd_type  cmd;
   stat_type stat;

   // sequencer: one command per cycle, none while a result waits for the output register
   ihpq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // heap and slot RAMs, sift registers, output word
   ihpq_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
